[design/wsfd_pkg.sv]
// Package for the WebSocket frame decoder.
// Holds parser phase codes, result kind codes and the result struct.
// No dependencies.
package wsfd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;

    // Parser phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Header constants
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;
    localparam logic [3:0] OPC_PING    = 4'h9;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic              fin;
        logic [3:0]        opcode;
        logic              is_ping;
        logic              last_of_frame;
    } t_result;

endpackage

[design/wsfd_if.sv]
// Stream interfaces for the WebSocket frame decoder: received bytes in,
// result items out. Depends on wsfd_pkg.
interface wsfd_in_if import wsfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_out_if import wsfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic              fin;
    logic [3:0]        opcode;
    logic              is_ping;
    logic              last_of_frame;

    modport source (output valid, output kind, output data, output fin, output opcode,
                    output is_ping, output last_of_frame, input ready);
    modport sink   (input valid, input kind, input data, input fin, input opcode,
                    input is_ping, input last_of_frame, output ready);
endinterface

[design/wsfd_parser.sv]
// Frame parser: header, extended length, mask key and payload unmasking.
// Produces at most one result per accepted byte. Depends on wsfd_pkg.
module wsfd_parser import wsfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [LEN_W-1:0]  i_max_len,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [2:0]       r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_mask_on, n_mask_on;
    logic [3:0]       r_cnt, n_cnt;
    logic [31:0]      r_key, n_key;
    logic [LEN_W-1:0] r_len_lo, n_len_lo;
    logic             r_len_hi_nz, n_len_hi_nz;
    logic [LEN_W-1:0] r_left, n_left;
    logic [1:0]       r_idx, n_idx;

    logic              res_valid;
    t_result           res;
    logic              do_len;
    logic              do_hdr;
    logic [6:0]        len7;
    logic [BYTE_W-1:0] mask_byte;
    logic              last;

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_mask_on   = r_mask_on;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_len_lo    = r_len_lo;
        n_len_hi_nz = r_len_hi_nz;
        n_left      = r_left;
        n_idx       = r_idx;
        do_len      = 1'b0;
        do_hdr      = 1'b0;
        len7        = i_rx_byte[6:0];
        mask_byte   = '0;
        last        = 1'b0;
        res_valid   = 1'b0;
        res.kind          = KIND_BYTE;
        res.data          = '0;
        res.fin           = r_fin;
        res.opcode        = r_opcode;
        res.is_ping       = (r_opcode == OPC_PING);
        res.last_of_frame = 1'b0;

        unique case (r_phase)
            PH_HDR0: begin
                n_fin    = i_rx_byte[7];
                n_opcode = i_rx_byte[3:0];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask_on   = i_rx_byte[7];
                n_key       = '0;
                n_len_lo    = '0;
                n_len_hi_nz = 1'b0;
                if (len7 == LEN7_EXT16) begin
                    n_cnt   = EXT16_BYTES;
                    n_phase = PH_EXT;
                end else if (len7 == LEN7_EXT64) begin
                    n_cnt   = EXT64_BYTES;
                    n_phase = PH_EXT;
                end else begin
                    n_len_lo = {{(LEN_W-7){1'b0}}, len7};
                    do_len   = 1'b1;
                end
            end
            PH_EXT: begin
                // Only the low 32 bits are kept; anything shifted beyond them
                // makes the length oversize, so a sticky flag is enough.
                n_len_lo    = {r_len_lo[LEN_W-9:0], i_rx_byte};
                n_len_hi_nz = r_len_hi_nz | (|r_len_lo[LEN_W-1:LEN_W-8]);
                n_cnt       = r_cnt - 4'd1;
                do_len      = (n_cnt == 4'd0);
            end
            PH_MASK: begin
                n_key  = {r_key[23:0], i_rx_byte};
                n_cnt  = r_cnt - 4'd1;
                do_hdr = (n_cnt == 4'd0);
            end
            PH_PAY: begin
                unique case (r_idx)
                    2'd0:    mask_byte = r_key[31:24];
                    2'd1:    mask_byte = r_key[23:16];
                    2'd2:    mask_byte = r_key[15:8];
                    default: mask_byte = r_key[7:0];
                endcase
                last              = (r_left == {{(LEN_W-1){1'b0}}, 1'b1});
                res_valid         = 1'b1;
                res.kind          = KIND_BYTE;
                res.data          = i_rx_byte ^ mask_byte;
                res.last_of_frame = last;
                n_left            = r_left - {{(LEN_W-1){1'b0}}, 1'b1};
                n_idx             = r_idx + 2'd1;
                if (last) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase

        if (do_len) begin
            if (n_len_hi_nz || (n_len_lo > i_max_len)) begin
                n_phase           = PH_HALT;
                res_valid         = 1'b1;
                res.kind          = KIND_ERROR;
                res.last_of_frame = 1'b1;
            end else if (n_mask_on) begin
                n_cnt   = MASK_BYTES;
                n_phase = PH_MASK;
            end else begin
                do_hdr = 1'b1;
            end
        end

        if (do_hdr) begin
            if (n_len_lo == '0) begin
                n_phase           = PH_HDR0;
                res_valid         = 1'b1;
                res.kind          = KIND_EMPTY;
                res.last_of_frame = 1'b1;
            end else begin
                n_left  = n_len_lo;
                n_idx   = 2'd0;
                n_phase = PH_PAY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_mask_on   <= n_mask_on;
            r_cnt       <= n_cnt;
            r_key       <= n_key;
            r_len_lo    <= n_len_lo;
            r_len_hi_nz <= n_len_hi_nz;
            r_left      <= n_left;
            r_idx       <= n_idx;
        end
    end

    assign o_res_valid = i_accept & res_valid;
    assign o_res       = res;

endmodule

[design/wsfd_out_reg.sv]
// Output register for result items; takes a new item whenever it is empty
// or its item is being taken. Depends on wsfd_pkg.
module wsfd_out_reg import wsfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[design/websocket_frame_decoder.sv]
// WebSocket frame decoder top level: one received byte per item in, at most one
// result item out per byte. A byte's result is loaded into the output register in the cycle after the byte is accepted.
// Throughput is one byte every cycle, set by the single parser state update;
// the input stalls only while the output register holds an untaken item.
// Synchronous active-low reset returns the parser to the first header byte,
// empties the output register and sets max_payload_len to 65536.
module websocket_frame_decoder import wsfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wsfd_in_if.sink          i_rx,
    wsfd_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    logic [LEN_W-1:0] r_max_len;
    logic             accept;
    logic             can_load;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    assign i_rx.ready = can_load;
    assign accept     = i_rx.valid && can_load;

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (can_load),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_res       (out_res)
    );

    assign o_res.kind          = out_res.kind;
    assign o_res.data          = out_res.data;
    assign o_res.fin           = out_res.fin;
    assign o_res.opcode        = out_res.opcode;
    assign o_res.is_ping       = out_res.is_ping;
    assign o_res.last_of_frame = out_res.last_of_frame;

endmodule

[verif/websocket_frame_decoder_tb.sv]
// Self-checking testbench for websocket_frame_decoder: drives a stream of frame bytes,
// predicts every result item and compares it field by field with the block's output.
// Depends on wsfd_pkg and the wsfd_in_if / wsfd_out_if interfaces.
module websocket_frame_decoder_tb;
    import wsfd_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_wdata;

    wsfd_in_if  rx_bus ();
    wsfd_out_if res_bus ();

    websocket_frame_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_rx        (rx_bus),
        .o_res       (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Frame parser state, mirrored from the block.
    logic [2:0]       parse_phase    = PH_HDR0;
    logic             hdr_fin        = 1'b0;
    logic [3:0]       hdr_opcode     = 4'd0;
    logic             hdr_masked     = 1'b0;
    logic [3:0]       hdr_bytes_left = 4'd0;
    logic [31:0]      mask_word      = 32'd0;
    logic [63:0]      frame_len      = 64'd0;
    logic [63:0]      pay_index      = 64'd0;
    logic [LEN_W-1:0] len_limit      = MAX_LEN_RESET;

    logic [7:0] tx_bytes[$];
    t_result    pending_results[$];
    t_result    predicted;
    t_result    seen;

    int bytes_queued = 0;
    int bytes_taken  = 0;
    int n_errors     = 0;
    int n_payload    = 0;
    int n_empty      = 0;
    int n_oversize   = 0;
    int n_ping       = 0;
    int n_limit_sets = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int pat_left     = 0;
    int quiet_cycles = 0;
    logic [15:0] ready_pat = 16'hFFFF;

    function automatic t_result make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic last);
        t_result r;
        r.kind          = kind;
        r.data          = data;
        r.fin           = hdr_fin;
        r.opcode        = hdr_opcode;
        r.is_ping       = (hdr_opcode == OPC_PING);
        r.last_of_frame = last;
        return r;
    endfunction

    // Length and mask are known: either the frame is empty or the payload starts.
    function automatic bit close_header(output t_result r);
        r = '0;
        if (frame_len == 64'd0) begin
            parse_phase = PH_HDR0;
            r = make_result(KIND_EMPTY, 8'h00, 1'b1);
            return 1'b1;
        end
        pay_index   = 64'd0;
        parse_phase = PH_PAY;
        return 1'b0;
    endfunction

    // The length limit is checked before any mask bytes are read.
    function automatic bit close_length(output t_result r);
        r = '0;
        if (frame_len > {32'd0, len_limit}) begin
            parse_phase = PH_HALT;
            r = make_result(KIND_ERROR, 8'h00, 1'b1);
            return 1'b1;
        end
        if (hdr_masked) begin
            hdr_bytes_left = MASK_BYTES;
            parse_phase    = PH_MASK;
            return 1'b0;
        end
        return close_header(r);
    endfunction

    function automatic bit parse_rx_byte(input logic [7:0] b, output t_result r);
        logic [7:0] key_byte;
        logic       last;
        r = '0;
        case (parse_phase)
            PH_HDR0: begin
                hdr_fin     = b[7];
                hdr_opcode  = b[3:0];
                parse_phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                hdr_masked = b[7];
                mask_word  = 32'd0;
                frame_len  = 64'd0;
                if (b[6:0] == LEN7_EXT16) begin
                    hdr_bytes_left = EXT16_BYTES;
                    parse_phase    = PH_EXT;
                    return 1'b0;
                end
                if (b[6:0] == LEN7_EXT64) begin
                    hdr_bytes_left = EXT64_BYTES;
                    parse_phase    = PH_EXT;
                    return 1'b0;
                end
                frame_len = {57'd0, b[6:0]};
                return close_length(r);
            end
            PH_EXT: begin
                frame_len      = {frame_len[55:0], b};
                hdr_bytes_left = hdr_bytes_left - 4'd1;
                if (hdr_bytes_left != 4'd0)
                    return 1'b0;
                return close_length(r);
            end
            PH_MASK: begin
                mask_word      = {mask_word[23:0], b};
                hdr_bytes_left = hdr_bytes_left - 4'd1;
                if (hdr_bytes_left != 4'd0)
                    return 1'b0;
                return close_header(r);
            end
            PH_PAY: begin
                key_byte  = 8'(mask_word >> (24 - 8 * pay_index[1:0]));
                last      = (pay_index + 64'd1 >= frame_len);
                r         = make_result(KIND_BYTE, b ^ key_byte, last);
                pay_index = pay_index + 64'd1;
                if (last)
                    parse_phase = PH_HDR0;
                return 1'b1;
            end
            default: begin
                // Once the stream has lost sync, every byte is dropped.
                parse_phase = PH_HALT;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            flag_error($sformatf("result item with none predicted: kind %0d data %02h",
                                 got.kind, got.data));
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", 8'(got.kind), 8'(want.kind));
        compare_field("data", got.data, want.data);
        compare_field("fin", 8'(got.fin), 8'(want.fin));
        compare_field("opcode", 8'(got.opcode), 8'(want.opcode));
        compare_field("is_ping", 8'(got.is_ping), 8'(want.is_ping));
        compare_field("last_of_frame", 8'(got.last_of_frame), 8'(want.last_of_frame));
    endtask

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
        bytes_queued++;
    endtask

    task automatic push_header(input logic [7:0] h0, input logic masked, input t_len_form form,
                               input logic [63:0] len, input logic [31:0] key);
        int i;
        push_byte(h0);
        case (form)
            LEN_SHORT: push_byte({masked, len[6:0]});
            LEN_EXT16: begin
                push_byte({masked, LEN7_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, LEN7_EXT64});
                for (i = 7; i >= 0; i--)
                    push_byte(len[8*i +: 8]);
            end
        endcase
        if (masked)
            for (i = 3; i >= 0; i--)
                push_byte(key[8*i +: 8]);
    endtask

    task automatic push_frame(input logic [7:0] h0, input logic masked, input t_len_form form,
                              input logic [63:0] len);
        int i;
        push_header(h0, masked, form, len, $urandom);
        for (i = 0; i < int'(len); i++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // Mostly short frames; the length is clamped so that it never exceeds the limit.
    task automatic push_random_frame();
        logic [7:0]  h0;
        logic [63:0] len;
        t_len_form   form;
        int          pick;
        h0 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0)
            h0[3:0] = OPC_PING;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            len = 64'd0;
        else if (pick < 65)
            len = 64'($urandom_range(1, 16));
        else if (pick < 85)
            len = 64'($urandom_range(17, 125));
        else if (pick < 95)
            len = 64'($urandom_range(0, 300));
        else
            len = 64'($urandom_range(0, 40));
        if (len > {32'd0, len_limit})
            len = {32'd0, len_limit};
        pick = $urandom_range(0, 99);
        if (len > 64'd125)
            form = (pick < 70) ? LEN_EXT16 : LEN_EXT64;
        else
            form = (pick < 80) ? LEN_SHORT : (pick < 92) ? LEN_EXT16 : LEN_EXT64;
        push_frame(h0, 1'($urandom_range(0, 1)), form, len);
    endtask

    // Hold the sender until every queued byte is taken and every result has come back.
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_len_limit(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_limit = value;
        n_limit_sets++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_bus.valid <= 1'b0;
        end else begin
            if (rx_bus.valid && rx_bus.ready) begin
                bytes_taken++;
                if (parse_rx_byte(rx_bus.rx_byte, predicted))
                    pending_results.insert(pending_results.size(), predicted);
            end
            if (!rx_bus.valid || rx_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_bus.valid <= 1'b0;
                end else if (tx_bytes.size() > 0) begin
                    rx_bus.valid   <= 1'b1;
                    rx_bus.rx_byte <= tx_bytes.pop_front();
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    rx_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready follows a rotating pattern that is redrawn now and then.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                seen.kind          = res_bus.kind;
                seen.data          = res_bus.data;
                seen.fin           = res_bus.fin;
                seen.opcode        = res_bus.opcode;
                seen.is_ping       = res_bus.is_ping;
                seen.last_of_frame = res_bus.last_of_frame;
                case (seen.kind)
                    KIND_BYTE:  n_payload++;
                    KIND_EMPTY: n_empty++;
                    default:    n_oversize++;
                endcase
                if (seen.is_ping)
                    n_ping++;
                check_result(seen);
            end
            if (pat_left <= 0) begin
                ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                pat_left  = $urandom_range(16, 64);
            end
            pat_left--;
            res_bus.ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Stream stalled for %0d cycles with %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'h00;
        res_bus.ready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Ping with no payload: one empty-frame item carrying the ping flag.
        push_header(8'h89, 1'b0, LEN_SHORT, 64'd0, 32'd0);
        // Masked fragment of five bytes, so the key index wraps around.
        push_header(8'h01, 1'b1, LEN_SHORT, 64'd5, 32'hFF00_A55A);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h5A);
        push_byte(8'hC3);
        push_byte(8'hFF);
        // Every bit of the first header byte set (reserved bits, opcode 15) with the 16-bit length form.
        push_header(8'hFF, 1'b0, LEN_EXT16, 64'd1, 32'd0);
        push_byte(8'h80);
        // The 64-bit length form announcing an empty frame.
        push_header(8'h00, 1'b0, LEN_EXT64, 64'd0, 32'd0);
        wait_idle();

        // A zero limit only lets empty frames through.
        set_len_limit('0);
        repeat (12) push_random_frame();
        wait_idle();

        set_len_limit(LEN_W'(7));
        push_frame(8'h82, 1'b1, LEN_SHORT, 64'd7);
        repeat (20) push_random_frame();
        wait_idle();

        set_len_limit('1);
        do begin
            repeat (6) push_random_frame();
            wait_idle();
        end while (bytes_queued < 350);

        set_len_limit(LEN_W'(300));
        push_frame(8'h81, 1'b0, LEN_SHORT, 64'd125);
        repeat (2) push_random_frame();
        wait_idle();

        set_len_limit(MAX_LEN_RESET);
        do begin
            repeat (2) push_random_frame();
            wait_idle();
        end while (bytes_queued < 780);

        // One more than the largest limit: error item, then the parser stays halted.
        set_len_limit('1);
        push_header(8'h82, 1'b1, LEN_EXT64, 64'h0000_0001_0000_0000, 32'h1234_5678);
        repeat (16) push_byte(8'($urandom_range(0, 255)));
        wait_idle();
        set_len_limit(MAX_LEN_RESET);
        push_byte(8'h89);
        push_byte(8'h00);
        repeat (10) push_byte(8'($urandom_range(0, 255)));
        wait_idle();
        repeat (8) @(posedge clk);

        if (pending_results.size() != 0)
            flag_error($sformatf("%0d predicted results never arrived", pending_results.size()));
        $display("Sent %0d bytes; checked %0d payload, %0d empty-frame, %0d oversize items",
                 bytes_taken, n_payload, n_empty, n_oversize);
        $display("(%0d ping); length limit set %0d times from zero to all ones",
                 n_ping, n_limit_sets);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
design/wsfd_pkg.sv
design/wsfd_if.sv
design/wsfd_parser.sv
design/wsfd_out_reg.sv
design/websocket_frame_decoder.sv
verif/websocket_frame_decoder_tb.sv
